// ----- src/sta_pkg.sv -----
// Shared types and constants for the slot table heap allocator.
// No dependencies; imported by sta_cell and slot_table_heap_allocator.
package sta_pkg;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_REINIT = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_NO_ROOM   = 3'd1,
    ST_FREED     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_REINIT    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CTL_IDLE = 2'd0,
    CTL_SCAN = 2'd1,
    CTL_HOLD = 2'd2
  } ctl_state_t;

  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  localparam logic [31:0] HEAP_BASE_RESET  = 32'h0010_0000;
  localparam logic [31:0] HEAP_LIMIT_RESET = 32'hFFFF_FFFF;

  // One request travelling down the row of slot cells.
  typedef struct packed {
    logic        valid;
    mode_t       mode;
    logic [31:0] size;
    logic [31:0] addr;
    logic [31:0] carve;    // carve pointer as seen by this request
    logic        done;     // a cell has already answered
    status_t     status;
    logic [31:0] granted;
  } token_t;

endpackage

// ----- src/sta_cell.sv -----
// One slot of the allocator table: holds a region and acts on a passing request.
// Depends on sta_pkg (token_t, mode_t, status_t).
module sta_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [31:0]     heap_limit,
  input  sta_pkg::token_t tok_in,
  output sta_pkg::token_t tok_out
);
  import sta_pkg::*;

  logic        used_r, used_nxt;
  logic        res_r, res_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] end_r, end_nxt;
  token_t      tok_r, tok_nxt;

  logic [32:0] carve_end;
  logic [31:0] old_len;

  assign carve_end = {1'b0, tok_in.carve} + {1'b0, tok_in.size};
  assign old_len   = end_r - start_r;

  always_comb begin
    used_nxt  = used_r;
    res_nxt   = res_r;
    start_nxt = start_r;
    end_nxt   = end_r;
    tok_nxt   = tok_in;
    if (tok_in.valid) begin
      case (tok_in.mode)
        MODE_ALLOC: begin
          if (!tok_in.done && !res_r) begin
            if (!used_r) begin
              tok_nxt.done = 1'b1;
              if (carve_end > {1'b0, heap_limit}) begin
                tok_nxt.status = ST_NO_ROOM;
              end else begin
                used_nxt        = 1'b1;
                res_nxt         = 1'b1;
                start_nxt       = tok_in.carve;
                end_nxt         = carve_end[31:0];
                tok_nxt.carve   = carve_end[31:0];
                tok_nxt.status  = ST_ALLOCATED;
                tok_nxt.granted = tok_in.carve;
              end
            end else if (old_len >= tok_in.size) begin
              res_nxt         = 1'b1;
              tok_nxt.done    = 1'b1;
              tok_nxt.status  = ST_ALLOCATED;
              tok_nxt.granted = start_r;
            end
          end
        end
        MODE_FREE: begin
          if (!tok_in.done && used_r && start_r == tok_in.addr) begin
            res_nxt        = 1'b0;
            tok_nxt.done   = 1'b1;
            tok_nxt.status = ST_FREED;
          end
        end
        MODE_REINIT: begin
          used_nxt = 1'b0;
          res_nxt  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= 1'b0;
      res_r       <= 1'b0;
      tok_r.valid <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      res_r       <= res_nxt;
      tok_r.valid <= tok_nxt.valid;
    end
    start_r       <= start_nxt;
    end_r         <= end_nxt;
    tok_r.mode    <= tok_nxt.mode;
    tok_r.size    <= tok_nxt.size;
    tok_r.addr    <= tok_nxt.addr;
    tok_r.carve   <= tok_nxt.carve;
    tok_r.done    <= tok_nxt.done;
    tok_r.status  <= tok_nxt.status;
    tok_r.granted <= tok_nxt.granted;
  end

  assign tok_out = tok_r;

endmodule

// ----- src/slot_table_heap_allocator.sv -----
// Top level of the slot table heap allocator: row of slot cells plus control.
// Depends on sta_pkg and sta_cell.
//
// Usage:
//   in_*  : one request item (mode, request_size, region_address), valid/ready.
//           mode 0 allocates, 1 frees, 2 reinitializes the table and carve
//           pointer, 3 does nothing and answers not found.
//   out_* : one result item per request (status, granted_address), valid/ready.
//   cfg_* : register writes, index 0 heap_base, index 1 heap_limit; always
//           ready. Write only while no request is in flight.
// Flow: a request walks the row of SLOTS cells, one cell per cycle, and its
//   result is then registered on out_*. One request is in the row at a time;
//   the next one is taken as soon as the previous result is in the output
//   register.
// Reset: all slots unused and free, carve pointer and heap_base at 0x100000,
//   heap_limit at 0xFFFFFFFF. No clearing pass is needed.
// Stall: a result waiting on out_ready stays in the output register; a
//   following result parks in a hold register and input is refused until
//   the output register frees up.
module slot_table_heap_allocator #(
  parameter int SLOTS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_mode,
  input  logic [31:0]           in_request_size,
  input  logic [31:0]           in_region_address,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_status,
  output logic [31:0]           out_granted_address,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [31:0]           cfg_data
);
  import sta_pkg::*;

  ctl_state_t  state_r, state_nxt;
  logic [31:0] heap_base_r, heap_limit_r;
  logic [31:0] carve_r, carve_nxt;

  logic        out_valid_r, out_valid_nxt;
  status_t     out_status_r, out_status_nxt;
  logic [31:0] out_granted_r, out_granted_nxt;
  status_t     hold_status_r, hold_status_nxt;
  logic [31:0] hold_granted_r, hold_granted_nxt;

  token_t      chain [SLOTS+1];
  token_t      entry;
  token_t      exit_tok;
  logic [SLOTS-1:0] chain_vld;
  logic        in_acc;

  assign in_ready  = (state_r == CTL_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Build the request token; set the default answer for the case no cell hits.
  always_comb begin
    entry.valid   = in_acc;
    entry.mode    = mode_t'(in_mode);
    entry.size    = in_request_size;
    entry.addr    = in_region_address;
    entry.carve   = (mode_t'(in_mode) == MODE_REINIT) ? heap_base_r : carve_r;
    entry.done    = 1'b0;
    entry.granted = '0;
    case (mode_t'(in_mode))
      MODE_ALLOC:  entry.status = ST_NO_ROOM;
      MODE_REINIT: entry.status = ST_REINIT;
      default:     entry.status = ST_NOT_FOUND;
    endcase
  end

  assign chain[0] = entry;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    sta_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .heap_limit (heap_limit_r),
      .tok_in     (chain[i]),
      .tok_out    (chain[i+1])
    );
    assign chain_vld[i] = chain[i+1].valid;
  end

  assign exit_tok = chain[SLOTS];

  // Control: wait for the token at the end of the row, then deliver or park it.
  always_comb begin
    state_nxt        = state_r;
    carve_nxt        = carve_r;
    out_valid_nxt    = out_valid_r;
    out_status_nxt   = out_status_r;
    out_granted_nxt  = out_granted_r;
    hold_status_nxt  = hold_status_r;
    hold_granted_nxt = hold_granted_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      CTL_IDLE: begin
        if (in_acc) begin
          state_nxt = CTL_SCAN;
        end
      end
      CTL_SCAN: begin
        if (exit_tok.valid) begin
          carve_nxt = exit_tok.carve;
          if (!out_valid_r || out_ready) begin
            out_valid_nxt   = 1'b1;
            out_status_nxt  = exit_tok.status;
            out_granted_nxt = exit_tok.granted;
            state_nxt       = CTL_IDLE;
          end else begin
            hold_status_nxt  = exit_tok.status;
            hold_granted_nxt = exit_tok.granted;
            state_nxt        = CTL_HOLD;
          end
        end
      end
      CTL_HOLD: begin
        if (out_ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = hold_status_r;
          out_granted_nxt = hold_granted_r;
          state_nxt       = CTL_IDLE;
        end
      end
      default: begin
        state_nxt = CTL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= CTL_IDLE;
      out_valid_r  <= 1'b0;
      carve_r      <= HEAP_BASE_RESET;
      heap_base_r  <= HEAP_BASE_RESET;
      heap_limit_r <= HEAP_LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      carve_r     <= carve_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HEAP_BASE:  heap_base_r  <= cfg_data;
          REG_HEAP_LIMIT: heap_limit_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
    out_status_r   <= out_status_nxt;
    out_granted_r  <= out_granted_nxt;
    hold_status_r  <= hold_status_nxt;
    hold_granted_r <= hold_granted_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_address = out_granted_r;

  // At most one request travels the row.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(chain_vld))
    else $error("more than one request in the slot row");

  // No request is in the row while the block takes input.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == CTL_IDLE |-> chain_vld == '0)
    else $error("request in flight while idle");

  // Only a successful allocation carries an address.
  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_ALLOCATED |-> out_granted_r == '0)
    else $error("address given without allocation");

  // A parked result only exists behind a stalled output.
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == CTL_HOLD |-> out_valid_r)
    else $error("hold state with empty output register");

endmodule

// ----- tb/sta_grant_checker.sv -----
// Scoreboard for the slot table heap allocator: mirrors the slot table and carve pointer.
// Depends on sta_pkg; sits beside the block in tb_top and watches all three channels.
module sta_grant_checker #(
  parameter int SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_request_size,
  input  logic [31:0] in_region_address,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_status,
  input  logic [31:0] out_granted_address,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          in_flight
);
  timeunit 1ns;
  timeprecision 1ps;
  import sta_pkg::*;

  typedef struct {
    status_t     status;
    logic [31:0] granted;
  } grant_t;

  logic [31:0] heap_base;
  logic [31:0] heap_limit;
  logic [31:0] carve_ptr;
  logic [31:0] slot_lo [SLOTS];
  logic [31:0] slot_hi [SLOTS];
  logic        slot_busy [SLOTS];
  logic        slot_touched [SLOTS];

  grant_t grant_queue [$];

  function automatic void clear_slots();
    for (int i = 0; i < SLOTS; i++) begin
      slot_lo[i]      = '0;
      slot_hi[i]      = '0;
      slot_busy[i]    = 1'b0;
      slot_touched[i] = 1'b0;
    end
  endfunction

  // Apply one request to the mirrored table and return the answer it earns.
  function automatic grant_t predict_grant(mode_t mode, logic [31:0] size,
                                           logic [31:0] addr);
    grant_t      g;
    logic [32:0] carve_end;
    bit          done;
    g.status  = ST_NOT_FOUND;
    g.granted = '0;
    done      = 1'b0;
    case (mode)
      MODE_ALLOC: begin
        g.status = ST_NO_ROOM;
        for (int i = 0; i < SLOTS && !done; i++) begin
          if (!slot_busy[i]) begin
            if (!slot_touched[i]) begin
              // the first fresh slot decides: carve here or give up
              carve_end = {1'b0, carve_ptr} + {1'b0, size};
              if (carve_end <= {1'b0, heap_limit}) begin
                slot_lo[i]      = carve_ptr;
                slot_hi[i]      = carve_end[31:0];
                carve_ptr       = carve_end[31:0];
                slot_touched[i] = 1'b1;
                slot_busy[i]    = 1'b1;
                g.status        = ST_ALLOCATED;
                g.granted       = slot_lo[i];
              end
              done = 1'b1;
            end else if (slot_hi[i] - slot_lo[i] >= size) begin
              slot_busy[i] = 1'b1;
              g.status     = ST_ALLOCATED;
              g.granted    = slot_lo[i];
              done         = 1'b1;
            end
          end
        end
      end
      MODE_FREE: begin
        for (int i = 0; i < SLOTS && !done; i++) begin
          if (slot_touched[i] && slot_lo[i] == addr) begin
            slot_busy[i] = 1'b0;
            g.status     = ST_FREED;
            done         = 1'b1;
          end
        end
      end
      MODE_REINIT: begin
        clear_slots();
        carve_ptr = heap_base;
        g.status  = ST_REINIT;
      end
      default: g.status = ST_NOT_FOUND;
    endcase
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      heap_base  = HEAP_BASE_RESET;
      heap_limit = HEAP_LIMIT_RESET;
      carve_ptr  = HEAP_BASE_RESET;
      clear_slots();
      grant_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_HEAP_BASE) heap_base = cfg_data;
        else heap_limit = cfg_data;
      end
      if (in_valid && in_ready)
        grant_queue.push_back(predict_grant(mode_t'(in_mode), in_request_size,
                                            in_region_address));
      if (out_valid && out_ready) begin
        if (grant_queue.size() == 0) begin
          fail_count++;
          $display("%0t: unrequested result, status %0d address %h", $time,
                   out_status, out_granted_address);
        end else begin
          want = grant_queue.pop_front();
          if (out_status !== want.status) begin
            fail_count++;
            $display("%0t: status expected %0d, actual %0d", $time, want.status,
                     out_status);
          end
          if (out_granted_address !== want.granted) begin
            fail_count++;
            $display("%0t: granted_address expected %h, actual %h", $time,
                     want.granted, out_granted_address);
          end
        end
      end
    end
    in_flight <= grant_queue.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// Top of the slot table heap allocator bench: clock, reset, request and register stimulus.
// Depends on sta_pkg, slot_table_heap_allocator and sta_grant_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sta_pkg::*;

  localparam int SLOT_COUNT      = 32;
  localparam int DRAIN_CYCLES    = SLOT_COUNT + 8;   // margin past the walk of a request down the row
  localparam int HOLD_OFF_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = MODE_NONE;
  logic [31:0] in_request_size = '0;
  logic [31:0] in_region_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_granted_address;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_HEAP_BASE;
  logic [31:0] cfg_data = '0;

  int fail_count;
  int in_flight;

  // Idle rates in percent of cycles for each side.
  int tx_idle_pct = 22;
  int rx_idle_pct = 80;

  // Long receiver hold-off: flip the token to start one.
  bit hold_token = 1'b0;
  bit hold_seen  = 1'b0;
  int hold_left  = 0;

  // Recent granted addresses, so that most frees hit a live region.
  bit [31:0] grant_log [64];
  bit [5:0]  grant_wr = '0;

  slot_table_heap_allocator #(
    .SLOTS(SLOT_COUNT)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_request_size    (in_request_size),
    .in_region_address  (in_region_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_granted_address(out_granted_address),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  sta_grant_checker #(
    .SLOTS(SLOT_COUNT)
  ) i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_request_size    (in_request_size),
    .in_region_address  (in_region_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_granted_address(out_granted_address),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .in_flight          (in_flight)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: honor a pending hold-off first, else drop ready at the idle rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Record every granted address as it leaves the block.
  always @(posedge clk) begin
    if (out_valid && out_ready && out_status == ST_ALLOCATED) begin
      grant_log[grant_wr] <= out_granted_address;
      grant_wr <= grant_wr + 1'b1;
    end
  end

  // Offer one item; hold valid and payload until the block takes it. Valid is
  // left high on return so a back-to-back item needs no second assignment.
  task automatic push_request(mode_t mode, logic [31:0] size, logic [31:0] addr);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_mode           <= mode;
    in_request_size   <= size;
    in_region_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every answer is back and the row is empty.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back, keeping cfg_valid high between them.
  task automatic write_heap_bounds(logic [31:0] base, logic [31:0] limit);
    cfg_valid <= 1'b1;
    cfg_index <= REG_HEAP_BASE;
    cfg_data  <= base;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_HEAP_LIMIT;
    cfg_data  <= limit;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly allocate and free with live addresses; a little reinit and noise.
  task automatic run_random(int count, int free_pct, logic [31:0] size_cap);
    int          pick;
    logic [31:0] size;
    logic [31:0] addr;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      addr = $urandom;
      case ($urandom_range(9))
        0, 1:    size = '0;
        7, 8:    size = $urandom_range(32'h1000);
        9:       size = $urandom;
        default: size = $urandom_range(size_cap);
      endcase
      if (pick < 1) begin
        push_request(MODE_REINIT, size, addr);
      end else if (pick < 3) begin
        push_request(MODE_NONE, size, addr);
      end else if (pick < 3 + free_pct) begin
        // most frees aim at a granted region, some at a random address
        if ($urandom_range(4) != 0) addr = grant_log[$urandom_range(63)];
        push_request(MODE_FREE, size, addr);
      end else begin
        push_request(MODE_ALLOC, size, addr);
      end
    end
  endtask

  initial begin
    logic [31:0] base;
    logic [31:0] span;
    logic [31:0] limit;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, on reset registers: carve pointer starts at the base reset value.
    push_request(MODE_ALLOC, 32'h0, 32'h0);           // empty region, pointer stays
    push_request(MODE_ALLOC, 32'h100, 32'hFFFF_FFFF);
    push_request(MODE_FREE, 32'hFFFF_FFFF, 32'h0010_0000);
    push_request(MODE_FREE, 32'h0, 32'h0010_0000);    // free of a free slot
    push_request(MODE_ALLOC, 32'h10, 32'h0);          // old empty region too short
    push_request(MODE_ALLOC, 32'h0, 32'h0);           // empty region fits size zero
    push_request(MODE_FREE, 32'h0, 32'hDEAD_BEEF);    // not found
    push_request(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(MODE_ALLOC, 32'hFFFF_FFFF, 32'h0);   // past the limit
    push_request(MODE_FREE, 32'h0, 32'h0010_0100);
    push_request(MODE_ALLOC, 32'h8, 32'h0);           // reuse of a longer old region
    push_request(MODE_REINIT, 32'h0, 32'h0);

    // Carve right up to the top of the address space.
    wait_quiet();
    write_heap_bounds(32'hFFFF_FFF0, 32'hFFFF_FFFF);
    push_request(MODE_REINIT, 32'h0, 32'h0);
    push_request(MODE_ALLOC, 32'h10, 32'h0);          // would wrap: no room
    push_request(MODE_ALLOC, 32'hF, 32'h0);
    push_request(MODE_ALLOC, 32'h0, 32'h0);
    push_request(MODE_ALLOC, 32'h1, 32'h0);

    // Base and limit both zero: only empty regions fit.
    wait_quiet();
    write_heap_bounds(32'h0, 32'h0);
    push_request(MODE_REINIT, 32'h0, 32'h0);
    push_request(MODE_ALLOC, 32'h0, 32'h0);
    push_request(MODE_ALLOC, 32'h1, 32'h0);
    push_request(MODE_FREE, 32'h0, 32'h0);

    // Random, sender idle now and then, receiver mostly idle.
    wait_quiet();
    write_heap_bounds(HEAP_BASE_RESET, HEAP_LIMIT_RESET);
    push_request(MODE_REINIT, 32'h0, 32'h0);
    run_random(180, 35, 32'h100);

    // Tight window so the limit bites often.
    wait_quiet();
    write_heap_bounds(32'h0000_4000, 32'h0000_4800);
    push_request(MODE_REINIT, 32'h0, 32'h0);
    run_random(180, 30, 32'h80);

    // Swap idle rates.
    tx_idle_pct = 80;
    rx_idle_pct <= 22;

    // Limit below base: every carve fails.
    wait_quiet();
    write_heap_bounds(32'h8000_0000, 32'h7FFF_FFFF);
    push_request(MODE_REINIT, 32'h0, 32'h0);
    run_random(120, 35, 32'h100);

    // Random window anywhere; clamp the limit at the top of the space.
    wait_quiet();
    base  = $urandom;
    span  = $urandom_range(32'h2_0000);
    limit = (base > ~span) ? 32'hFFFF_FFFF : base + span;
    write_heap_bounds(base, limit);
    push_request(MODE_REINIT, 32'h0, 32'h0);
    run_random(180, 30, 32'h400);

    // Neither side idles; start with a long receiver hold-off to fill the block.
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    wait_quiet();
    write_heap_bounds(32'hFFFF_F000, 32'hFFFF_FFFF);
    push_request(MODE_REINIT, 32'h0, 32'h0);
    hold_token <= ~hold_token;
    run_random(200, 25, 32'h100);

    wait_quiet();
    write_heap_bounds(32'h0, 32'h0000_FFFF);
    push_request(MODE_REINIT, 32'h0, 32'h0);
    run_random(200, 40, 32'h200);

    wait_quiet();
    if (fail_count == 0 && in_flight == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
